// ===== sv/vlrt_pkg.sv =====
// Shared types and constants for the virtual interrupt list register table.
// Used by every module of the block; depends on nothing else.
package vlrt_pkg;

  localparam int NUM_VCPUS = 8;
  localparam int NUM_SLOTS = 4;
  localparam int ROW_W = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_QUERY = 3'd1;
  localparam logic [2:0] CMD_FIND_EMPTY = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_SAVE = 3'd4;

  localparam int STATE_LSB = 28;
  localparam int STATE_MSB = 29;
  localparam int ID_MSB = 9;

  typedef logic [NUM_SLOTS-1:0][31:0] row_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  vcpu;
    logic [1:0]  slot;
    logic [9:0]  interrupt_id;
    logic [31:0] entry_word;
  } req_word_t;

  typedef struct packed {
    logic       vcpu_ok;
    logic       id_present;
    logic       empty_found;
    logic [1:0] empty_index;
    logic [3:0] cleared_slots;
  } rsp_word_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    row_t             data;
  } tbl_wr_t;

  function automatic logic is_live(input logic [31:0] w);
    return w[STATE_MSB:STATE_LSB] != 2'b00;
  endfunction

endpackage

// ===== sv/vlrt_table.sv =====
// Register file holding one row of list register words per virtual CPU.
// Depends on vlrt_pkg for the row and write port types.
module vlrt_table
  import vlrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [ROW_W-1:0] rd_row,
  output row_t             rd_data,
  input  tbl_wr_t          wr
);

  row_t rows [NUM_VCPUS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_VCPUS; r++) begin
        rows[r] <= '0;
      end
    end else if (wr.en) begin
      rows[wr.row] <= wr.data;
    end
  end

  assign rd_data = rows[rd_row];

endmodule

// ===== sv/vlrt_exec.sv =====
// Combinational command logic: evaluates one word against the addressed row
// and produces the response and the row update. Depends on vlrt_pkg.
module vlrt_exec
  import vlrt_pkg::*;
(
  input  req_word_t  req,
  input  logic [3:0] active_vcpus,
  input  row_t       row,
  output rsp_word_t  rsp,
  output tbl_wr_t    upd
);

  logic                 vcpu_ok;
  logic [NUM_SLOTS-1:0] hit;
  logic [NUM_SLOTS-1:0] empty;
  logic                 found;
  logic [1:0]           eidx;
  logic [3:0]           cleared;
  row_t                 new_row;

  assign vcpu_ok = ({1'b0, req.vcpu} < active_vcpus) && (5'(req.vcpu) < 5'(NUM_VCPUS));

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit[i]   = is_live(row[i]) && (row[i][ID_MSB:0] == req.interrupt_id);
      empty[i] = !is_live(row[i]);
    end
  end

  // Lowest empty slot wins.
  always_comb begin
    found = 1'b0;
    eidx  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (empty[i] && !found) begin
        found = 1'b1;
        eidx  = 2'(i);
      end
    end
  end

  always_comb begin
    cleared = '0;
    for (int i = 0; i < NUM_SLOTS && i < 4; i++) begin
      cleared[i] = hit[i];
    end
  end

  always_comb begin
    new_row = row;
    upd.en  = 1'b0;
    rsp     = '0;
    unique case (req.command)
      CMD_WRITE, CMD_SAVE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (5'(req.slot) == 5'(i)) begin
            upd.en = 1'b1;
            if (req.command == CMD_SAVE && !is_live(req.entry_word)) begin
              new_row[i] = '0;
            end else begin
              new_row[i] = req.entry_word;
            end
          end
        end
      end
      CMD_QUERY: begin
        rsp.id_present = |hit;
      end
      CMD_FIND_EMPTY: begin
        rsp.empty_found = found;
        rsp.empty_index = found ? eidx : 2'd0;
      end
      CMD_CLEAR: begin
        upd.en = |hit;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (hit[i]) begin
            new_row[i] = '0;
          end
        end
        rsp.cleared_slots = cleared;
      end
      default: begin
      end
    endcase
    rsp.vcpu_ok = 1'b1;
    if (!vcpu_ok) begin
      rsp    = '0;
      upd.en = 1'b0;
    end
    upd.row  = ROW_W'(req.vcpu);
    upd.data = new_row;
  end

endmodule

// ===== sv/vgic_list_register_table_unit.sv =====
// Throughput: one word per cycle while rsp_stall is low. Each accepted word is held in
// an input register, evaluated combinationally against its virtual CPU's row of list
// registers, and the row is rewritten at the same edge that loads the response register,
// so back-to-back commands to the same virtual CPU always see each other's updates. The
// rate is set by that combinational read-modify-write of the addressed row. The table
// is all zero after reset and active_vcpus is 1; cfg_we writes active_vcpus and should
// only be used while idle.
module vgic_list_register_table_unit
  import vlrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_word_t  req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_word_t  rsp
);

  logic [3:0] active_vcpus;
  logic       s1_valid;
  req_word_t  s1_word;
  logic       s1_advance;
  row_t       row;
  rsp_word_t  result;
  tbl_wr_t    upd;
  tbl_wr_t    wr;

  assign s1_advance = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall  = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_vcpus <= 4'd1;
    end else if (cfg_we) begin
      active_vcpus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_word <= req;
    end
  end

  vlrt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_row  (ROW_W'(s1_word.vcpu)),
    .rd_data (row),
    .wr      (wr)
  );

  vlrt_exec u_exec (
    .req          (s1_word),
    .active_vcpus (active_vcpus),
    .row          (row),
    .rsp          (result),
    .upd          (upd)
  );

  always_comb begin
    wr    = upd;
    wr.en = upd.en && s1_advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp <= result;
    end
  end

endmodule

// ===== sv/vlrt_checker.sv =====
// Port-level checks for vgic_list_register_table_unit, attached by bind.
// Depends on vlrt_pkg for the word types.
module vlrt_checker
  import vlrt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input rsp_word_t  rsp
);

  // A stalled response word stays in place unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // The input side only backs up when the response side is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a stalled response");

  // A word for an invalid virtual CPU reports nothing.
  a_bad_vcpu_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.vcpu_ok |-> rsp == '0)
    else $error("invalid vcpu response carries data");

  // Only one command's report can appear in one response.
  a_one_report: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot0({rsp.id_present, rsp.empty_found, |rsp.cleared_slots}))
    else $error("response mixes reports of different commands");

  a_index_needs_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.empty_index != 2'd0 |-> rsp.empty_found)
    else $error("empty index without an empty slot found");

endmodule

bind vgic_list_register_table_unit vlrt_checker u_vlrt_checker (.*);
